/* hw/rtl/atlc_pkg.sv */
// ----------------------------------------------------------------------------
// atlc_pkg
// Shared types and constants of the adaptive traffic light controller.
// ----------------------------------------------------------------------------
package atlc_pkg;

   // Field widths
   localparam int unsigned CFG_W     = 16;
   localparam int unsigned SPEED_W   = 12;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned LEN_W     = 18;   // base + extension + rain extra
   localparam int unsigned SUM_W     = 17;   // sum of two config values
   localparam int unsigned MOD_W     = 10;   // value modulo the blink period

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GREEN       = 3'd0,
      CSR_AMBER_BASE  = 3'd1,
      CSR_RED_MIN     = 3'd2,
      CSR_WALK        = 3'd3,
      CSR_BLINK       = 3'd4,
      CSR_AMBER_EXTRA = 3'd5,
      CSR_RAIN_EXTRA  = 3'd6
   } csr_index_type;

   // Register reset values (ms)
   localparam logic [CFG_W-1:0] RST_GREEN       = 16'd6000;
   localparam logic [CFG_W-1:0] RST_AMBER_BASE  = 16'd3000;
   localparam logic [CFG_W-1:0] RST_RED_MIN     = 16'd5000;
   localparam logic [CFG_W-1:0] RST_WALK        = 16'd2000;
   localparam logic [CFG_W-1:0] RST_BLINK       = 16'd4000;
   localparam logic [CFG_W-1:0] RST_AMBER_EXTRA = 16'd3000;
   localparam logic [CFG_W-1:0] RST_RAIN_EXTRA  = 16'd2000;

   // Speed thresholds in cm/s with 4 fraction bits: 5, 20 and 50 cm/s
   localparam logic [SPEED_W-1:0] SPEED_LOW_Q4  = 12'd80;
   localparam logic [SPEED_W-1:0] SPEED_MID_Q4  = 12'd320;
   localparam logic [SPEED_W-1:0] SPEED_HIGH_Q4 = 12'd800;

   // Scaled extension: extra * (800 - v) / 480, with 480 = 32 * 15
   localparam int unsigned SPAN_W        = 9;
   localparam int unsigned EXT_PROD_W    = CFG_W + SPAN_W;
   localparam int unsigned EXT_SHIFT     = 5;
   localparam int unsigned EXT_Q_W       = EXT_PROD_W - EXT_SHIFT;
   localparam int unsigned DIV15_RECIP_W = 21;
   localparam int unsigned DIV15_SHIFT   = 24;
   localparam int unsigned DIV15_PROD_W  = EXT_Q_W + DIV15_RECIP_W;
   localparam logic [DIV15_RECIP_W-1:0] DIV15_RECIP = 21'd1118482;  // ceil(2^24/15)

   // Pedestrian blink: 500 ms on, 500 ms off
   localparam logic [MOD_W-1:0] BLINK_PERIOD_MS = 10'd1000;
   localparam logic [MOD_W-1:0] BLINK_LAST_MS   = 10'd999;
   localparam logic [MOD_W-1:0] BLINK_ON_MS     = 10'd500;
   localparam int unsigned DIV1000_RECIP_W = 17;
   localparam int unsigned DIV1000_SHIFT   = 26;
   localparam int unsigned DIV1000_PROD_W  = CFG_W + DIV1000_RECIP_W;
   localparam int unsigned WALK_Q_W        = DIV1000_PROD_W - DIV1000_SHIFT;
   localparam logic [DIV1000_RECIP_W-1:0] DIV1000_RECIP = 17'd67109;  // ceil(2^26/1000)
   localparam logic [WALK_Q_W-1:0] RST_WALK_Q   = 7'd2;
   localparam logic [MOD_W-1:0]    RST_WALK_MOD = 10'd0;

   // Car phases
   typedef enum logic [1:0] {
      PH_GREEN = 2'd0,
      PH_AMBER = 2'd1,
      PH_RED   = 2'd2
   } phase_type;

   // Amber extension kind
   typedef enum logic [1:0] {
      EXT_NONE   = 2'd0,
      EXT_FULL   = 2'd1,
      EXT_SCALED = 2'd2
   } ext_mode_type;

   typedef struct packed {
      logic               vehicle_present;
      logic [SPEED_W-1:0] speed_q4;
      logic               raining;
   } req_type;

   typedef struct packed {
      logic               car_green;
      logic               car_amber;
      logic               car_red;
      logic               walk_green;
      logic               walk_red;
      logic [1:0]         phase;
      logic               speed_report;
      logic [SPEED_W-1:0] reported_speed;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] green_ms;
      logic [CFG_W-1:0] amber_base_ms;
      logic [CFG_W-1:0] red_min_ms;
      logic [CFG_W-1:0] walk_ms;
      logic [CFG_W-1:0] blink_ms;
      logic [CFG_W-1:0] amber_max_extra_ms;
      logic [CFG_W-1:0] rain_extra_ms;
      logic [MOD_W-1:0] walk_mod;        // walk_ms modulo the blink period
   } cfg_type;

   typedef struct packed {
      req_type          item;
      logic [LEN_W-1:0] amber_len;
   } amb_type;

endpackage

/* hw/rtl/atlc_csr.sv */
// ----------------------------------------------------------------------------
// atlc_csr
// Timing registers, plus walk time modulo the blink period for the phase unit.
// ----------------------------------------------------------------------------
module atlc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [atlc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [atlc_pkg::CFG_W-1:0]            csr_wdata,
   output atlc_pkg::cfg_type                     cfg
);

   logic [atlc_pkg::CFG_W-1:0]          green_ff, amber_base_ff, red_min_ff, walk_ff;
   logic [atlc_pkg::CFG_W-1:0]          blink_ff, amber_extra_ff, rain_extra_ff;
   logic [atlc_pkg::CFG_W-1:0]          green_in, amber_base_in, red_min_in, walk_in;
   logic [atlc_pkg::CFG_W-1:0]          blink_in, amber_extra_in, rain_extra_in;
   logic [atlc_pkg::WALK_Q_W-1:0]       walk_q_ff, walk_q_in;
   logic [atlc_pkg::MOD_W-1:0]          walk_mod_ff, walk_mod_in;
   logic [atlc_pkg::DIV1000_PROD_W-1:0] walk_prod;
   logic [atlc_pkg::CFG_W-1:0]          walk_rem;

   // writes never stall
   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      green_in       = green_ff;
      amber_base_in  = amber_base_ff;
      red_min_in     = red_min_ff;
      walk_in        = walk_ff;
      blink_in       = blink_ff;
      amber_extra_in = amber_extra_ff;
      rain_extra_in  = rain_extra_ff;
      if (csr_valid) begin
         case (atlc_pkg::csr_index_type'(csr_index))
            atlc_pkg::CSR_GREEN:       green_in       = csr_wdata;
            atlc_pkg::CSR_AMBER_BASE:  amber_base_in  = csr_wdata;
            atlc_pkg::CSR_RED_MIN:     red_min_in     = csr_wdata;
            atlc_pkg::CSR_WALK:        walk_in        = csr_wdata;
            atlc_pkg::CSR_BLINK:       blink_in       = csr_wdata;
            atlc_pkg::CSR_AMBER_EXTRA: amber_extra_in = csr_wdata;
            atlc_pkg::CSR_RAIN_EXTRA:  rain_extra_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // walk mod 1000: registered reciprocal quotient, then the remainder from it, also registered
   assign walk_prod = atlc_pkg::DIV1000_PROD_W'(walk_ff)
                    * atlc_pkg::DIV1000_PROD_W'(atlc_pkg::DIV1000_RECIP);
   assign walk_q_in = walk_prod[atlc_pkg::DIV1000_SHIFT +: atlc_pkg::WALK_Q_W];
   assign walk_rem  = walk_ff - atlc_pkg::CFG_W'(walk_q_ff)
                    * atlc_pkg::CFG_W'(atlc_pkg::BLINK_PERIOD_MS);
   assign walk_mod_in = walk_rem[atlc_pkg::MOD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         green_ff       <= atlc_pkg::RST_GREEN;
         amber_base_ff  <= atlc_pkg::RST_AMBER_BASE;
         red_min_ff     <= atlc_pkg::RST_RED_MIN;
         walk_ff        <= atlc_pkg::RST_WALK;
         blink_ff       <= atlc_pkg::RST_BLINK;
         amber_extra_ff <= atlc_pkg::RST_AMBER_EXTRA;
         rain_extra_ff  <= atlc_pkg::RST_RAIN_EXTRA;
         walk_q_ff      <= atlc_pkg::RST_WALK_Q;
         walk_mod_ff    <= atlc_pkg::RST_WALK_MOD;
      end else begin
         green_ff       <= green_in;
         amber_base_ff  <= amber_base_in;
         red_min_ff     <= red_min_in;
         walk_ff        <= walk_in;
         blink_ff       <= blink_in;
         amber_extra_ff <= amber_extra_in;
         rain_extra_ff  <= rain_extra_in;
         walk_q_ff      <= walk_q_in;
         walk_mod_ff    <= walk_mod_in;
      end
   end

   assign cfg.green_ms           = green_ff;
   assign cfg.amber_base_ms      = amber_base_ff;
   assign cfg.red_min_ms         = red_min_ff;
   assign cfg.walk_ms            = walk_ff;
   assign cfg.blink_ms           = blink_ff;
   assign cfg.amber_max_extra_ms = amber_extra_ff;
   assign cfg.rain_extra_ms      = rain_extra_ff;
   assign cfg.walk_mod           = walk_mod_ff;

endmodule

/* hw/rtl/atlc_amber.sv */
// ----------------------------------------------------------------------------
// atlc_amber
// Three-stage pipeline: input register, extension product, divide by 480.
// Emits each tick with its amber duration attached.
// ----------------------------------------------------------------------------
module atlc_amber (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  atlc_pkg::req_type  in_item,
   input  atlc_pkg::cfg_type  cfg,
   output logic               out_valid,
   input  logic               out_ready,
   output atlc_pkg::amb_type  out_data
);

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in;
   logic s1_ready, s2_ready, s3_ready;

   atlc_pkg::req_type                  s1_item_ff, s2_item_ff, s3_item_ff;
   atlc_pkg::ext_mode_type             s2_mode_ff, s3_mode_ff, mode_in;
   logic [atlc_pkg::EXT_Q_W-1:0]       s2_q_ff, q_in;
   logic [atlc_pkg::SUM_W-1:0]         s2_base_ff, s3_base_ff, base_in;
   logic [atlc_pkg::CFG_W-1:0]         s3_quot_ff, quot_in;
   logic [atlc_pkg::SPEED_W-1:0]       span_full;
   logic [atlc_pkg::EXT_PROD_W-1:0]    ext_prod;
   logic [atlc_pkg::DIV15_PROD_W-1:0]  div_prod;
   logic [atlc_pkg::CFG_W-1:0]         ext_ms;

   // stage ready chain: a stage loads when empty or when it drains
   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   assign s1_valid_in = s1_ready ? in_valid    : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   // stage 1 -> 2: classify speed, extension product, base plus rain
   always_comb begin
      mode_in = atlc_pkg::EXT_NONE;
      if (s1_item_ff.vehicle_present && s1_item_ff.speed_q4 > atlc_pkg::SPEED_LOW_Q4) begin
         if (s1_item_ff.speed_q4 < atlc_pkg::SPEED_MID_Q4)
            mode_in = atlc_pkg::EXT_FULL;
         else if (s1_item_ff.speed_q4 < atlc_pkg::SPEED_HIGH_Q4)
            mode_in = atlc_pkg::EXT_SCALED;
      end
   end

   assign span_full = atlc_pkg::SPEED_HIGH_Q4 - s1_item_ff.speed_q4;
   assign ext_prod  = atlc_pkg::EXT_PROD_W'(cfg.amber_max_extra_ms)
                    * atlc_pkg::EXT_PROD_W'(span_full[atlc_pkg::SPAN_W-1:0]);
   assign q_in      = ext_prod[atlc_pkg::EXT_PROD_W-1:atlc_pkg::EXT_SHIFT];
   assign base_in   = atlc_pkg::SUM_W'(cfg.amber_base_ms)
                    + (s1_item_ff.raining ? atlc_pkg::SUM_W'(cfg.rain_extra_ms)
                                          : atlc_pkg::SUM_W'(0));

   // stage 2 -> 3: exact divide by 15 through the reciprocal
   assign div_prod = atlc_pkg::DIV15_PROD_W'(s2_q_ff)
                   * atlc_pkg::DIV15_PROD_W'(atlc_pkg::DIV15_RECIP);
   assign quot_in  = div_prod[atlc_pkg::DIV15_SHIFT +: atlc_pkg::CFG_W];

   // stage 3 output: pick the extension, total amber duration
   always_comb begin
      case (s3_mode_ff)
         atlc_pkg::EXT_FULL:   ext_ms = cfg.amber_max_extra_ms;
         atlc_pkg::EXT_SCALED: ext_ms = s3_quot_ff;
         default:              ext_ms = '0;
      endcase
   end

   assign out_valid          = s3_valid_ff;
   assign out_data.item      = s3_item_ff;
   assign out_data.amber_len = atlc_pkg::LEN_W'(s3_base_ff) + atlc_pkg::LEN_W'(ext_ms);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (s1_ready && in_valid) begin
         s1_item_ff <= in_item;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_item_ff <= s1_item_ff;
         s2_mode_ff <= mode_in;
         s2_q_ff    <= q_in;
         s2_base_ff <= base_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_item_ff <= s2_item_ff;
         s3_mode_ff <= s2_mode_ff;
         s3_quot_ff <= quot_in;
         s3_base_ff <= s2_base_ff;
      end
   end

endmodule

/* hw/rtl/atlc_phase.sv */
// ----------------------------------------------------------------------------
// atlc_phase
// Phase state machine with saturating elapsed timer and the result register.
// ----------------------------------------------------------------------------
module atlc_phase #(
   parameter int unsigned TIMER_WIDTH = 18
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  atlc_pkg::amb_type  in_data,
   input  atlc_pkg::cfg_type  cfg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output atlc_pkg::rsp_type  rsp_data
);

   localparam int unsigned CW =
      (TIMER_WIDTH > atlc_pkg::LEN_W) ? TIMER_WIDTH : atlc_pkg::LEN_W;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

   atlc_pkg::phase_type         phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0]      elapsed_ff, elapsed_in, tick_ms;
   logic [atlc_pkg::MOD_W-1:0]  emod_ff, emod_in, tick_mod, blink_pos;
   logic [atlc_pkg::MOD_W:0]    blink_sum;
   logic                        flag_ff, flag_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   atlc_pkg::rsp_type           rsp_data_ff, rsp_data_in, rsp_cur;
   logic                        accept, saturated;
   logic [CW-1:0]               tick_c;
   logic [atlc_pkg::SUM_W-1:0]  blink_end;
   logic                        green_done, amber_done, red_done, in_walk, in_blink;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign accept   = in_valid && in_ready;

   // saturating timer and its value modulo the blink period
   assign saturated = (elapsed_ff == TIMER_MAX);
   assign tick_ms   = saturated ? elapsed_ff : elapsed_ff + TIMER_WIDTH'(1);
   assign tick_mod  = saturated ? emod_ff :
                      (emod_ff == atlc_pkg::BLINK_LAST_MS) ? '0 :
                      emod_ff + atlc_pkg::MOD_W'(1);
   assign tick_c    = CW'(tick_ms);

   // position inside the blink period, counted from the end of walk
   assign blink_sum = (tick_mod >= cfg.walk_mod)
                    ? {1'b0, tick_mod} - {1'b0, cfg.walk_mod}
                    : {1'b0, tick_mod} + {1'b0, atlc_pkg::BLINK_PERIOD_MS}
                      - {1'b0, cfg.walk_mod};
   assign blink_pos = blink_sum[atlc_pkg::MOD_W-1:0];

   // phase exit and window compares
   assign blink_end  = atlc_pkg::SUM_W'(cfg.walk_ms) + atlc_pkg::SUM_W'(cfg.blink_ms);
   assign green_done = tick_c >= CW'(cfg.green_ms);
   assign amber_done = tick_c >= CW'(in_data.amber_len);
   assign red_done   = tick_c >= CW'(cfg.red_min_ms);
   assign in_walk    = tick_c <  CW'(cfg.walk_ms);
   assign in_blink   = tick_c <  CW'(blink_end);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      emod_in    = emod_ff;
      flag_in    = flag_ff;
      if (accept) begin
         elapsed_in = tick_ms;
         emod_in    = tick_mod;
         case (phase_ff)
            atlc_pkg::PH_AMBER: begin
               if (in_data.item.vehicle_present)
                  flag_in = 1'b1;
               if (amber_done)
                  phase_in = atlc_pkg::PH_RED;
            end
            atlc_pkg::PH_RED: begin
               if (!in_walk && !in_blink && red_done)
                  phase_in = atlc_pkg::PH_GREEN;
            end
            default: begin
               if (green_done) begin
                  phase_in = atlc_pkg::PH_AMBER;
                  flag_in  = 1'b0;
               end
            end
         endcase
         // phase change restarts the timer
         if (phase_in != phase_ff) begin
            elapsed_in = '0;
            emod_in    = '0;
         end
      end
   end

   // lamps and report for the current tick
   always_comb begin
      rsp_cur = '0;
      rsp_cur.phase = phase_ff;
      case (phase_ff)
         atlc_pkg::PH_AMBER: begin
            rsp_cur.car_amber = 1'b1;
            rsp_cur.walk_red  = 1'b1;
            if (in_data.item.vehicle_present && !flag_ff
                && in_data.item.speed_q4 > atlc_pkg::SPEED_LOW_Q4) begin
               rsp_cur.speed_report   = 1'b1;
               rsp_cur.reported_speed = in_data.item.speed_q4;
            end
         end
         atlc_pkg::PH_RED: begin
            rsp_cur.car_red = 1'b1;
            if (in_walk)
               rsp_cur.walk_green = 1'b1;
            else if (in_blink)
               rsp_cur.walk_green = (blink_pos < atlc_pkg::BLINK_ON_MS);
            else
               rsp_cur.walk_red = 1'b1;
         end
         default: begin
            rsp_cur.car_green = 1'b1;
            rsp_cur.walk_red  = 1'b1;
         end
      endcase
   end

   // result register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = accept ? rsp_cur : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= atlc_pkg::PH_GREEN;
         elapsed_ff   <= '0;
         emod_ff      <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         elapsed_ff   <= elapsed_in;
         emod_ff      <= emod_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/adaptive_traffic_light_controller.sv */
// ----------------------------------------------------------------------------
// adaptive_traffic_light_controller
// Car and pedestrian lamp sequencer driven by 1 ms ticks, with amber
// stretched for rain and slow vehicles.
// ----------------------------------------------------------------------------
// One tick is accepted per clock cycle unless the result side stalls, and each
// yields one lamp/report result: three stages work out the amber duration of
// the tick (input register, extension product, divide by 480), and the phase
// unit updates phase, timer and report flag and loads the result register.
// Inputs and results flow under valid/ready; a stalled result does not block
// ticks from filling empty stages. Register writes are always accepted; the
// walk offset used for the blink pattern settles once a write to walk_ms has
// passed the walk, quotient and remainder registers.
module adaptive_traffic_light_controller #(
   parameter int unsigned TIMER_WIDTH = 18
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  atlc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output atlc_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [atlc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [atlc_pkg::CFG_W-1:0]      csr_wdata
);

   atlc_pkg::cfg_type cfg;
   atlc_pkg::amb_type amb_data;
   logic              amb_valid, amb_ready;

   // configuration registers
   atlc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // amber duration pipeline
   atlc_amber u_amber (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (req_data),
      .cfg       (cfg),
      .out_valid (amb_valid),
      .out_ready (amb_ready),
      .out_data  (amb_data)
   );

   // phase sequencer and result register
   atlc_phase #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_phase (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (amb_valid),
      .in_ready  (amb_ready),
      .in_data   (amb_data),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/atlc_checker.sv */
// ----------------------------------------------------------------------------
// atlc_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module atlc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input atlc_pkg::rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // exactly one car lamp, matching the reported phase
   a_car_lamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.car_green, rsp_data.car_amber, rsp_data.car_red})
         && (rsp_data.car_green == (rsp_data.phase == atlc_pkg::PH_GREEN))
         && (rsp_data.car_amber == (rsp_data.phase == atlc_pkg::PH_AMBER))
         && (rsp_data.car_red   == (rsp_data.phase == atlc_pkg::PH_RED)))
      else $error("car lamps disagree with phase");

   // pedestrians only walk under car red
   a_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.walk_green |-> rsp_data.car_red && !rsp_data.walk_red)
      else $error("pedestrian green outside car red");

   // reports only in amber above the speed floor, speed zero otherwise
   a_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.speed_report
         ? (rsp_data.car_amber && rsp_data.reported_speed > atlc_pkg::SPEED_LOW_Q4)
         : (rsp_data.reported_speed == '0)))
      else $error("bad speed report");

endmodule

bind adaptive_traffic_light_controller atlc_checker u_atlc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* verif/atlc_tb_pkg.sv */
// ----------------------------------------------------------------------------
// atlc_tb_pkg
// Lamp sequence predictor and result scoreboard for the traffic light testbench.
// ----------------------------------------------------------------------------
package atlc_tb_pkg;

   import atlc_pkg::*;

   localparam int unsigned         TICK_TIMER_W   = 18;
   localparam longint unsigned     TICK_TIMER_MAX = (64'd1 << TICK_TIMER_W) - 1;
   localparam longint unsigned     SCALED_EXT_DIV = 480;   // 30 cm/s span in q4
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED    = 3'd7;  // no register behind it

   class lamp_scoreboard;

      // timing registers as the block should hold them
      logic [CFG_W-1:0] green_len;
      logic [CFG_W-1:0] amber_base;
      logic [CFG_W-1:0] red_min;
      logic [CFG_W-1:0] walk_len;
      logic [CFG_W-1:0] blink_len;
      logic [CFG_W-1:0] amber_extra;
      logic [CFG_W-1:0] rain_extra;

      // sequencer state
      phase_type        light_phase;
      longint unsigned  phase_ms;
      bit               speed_sent;

      rsp_type          expected_lamps[$];
      int unsigned      errors;

      function new();
         green_len   = RST_GREEN;
         amber_base  = RST_AMBER_BASE;
         red_min     = RST_RED_MIN;
         walk_len    = RST_WALK;
         blink_len   = RST_BLINK;
         amber_extra = RST_AMBER_EXTRA;
         rain_extra  = RST_RAIN_EXTRA;
         light_phase = PH_GREEN;
         phase_ms    = 0;
         speed_sent  = 1'b0;
         errors      = 0;
      endfunction

      function void set_timing(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         case (index)
            CSR_GREEN:       green_len   = value;
            CSR_AMBER_BASE:  amber_base  = value;
            CSR_RED_MIN:     red_min     = value;
            CSR_WALK:        walk_len    = value;
            CSR_BLINK:       blink_len   = value;
            CSR_AMBER_EXTRA: amber_extra = value;
            CSR_RAIN_EXTRA:  rain_extra  = value;
            default: ;
         endcase
      endfunction

      // amber length for this tick's vehicle, speed and rain
      function longint unsigned amber_ms(req_type t);
         longint unsigned len;
         len = 64'(amber_base);
         if (t.vehicle_present && t.speed_q4 > SPEED_LOW_Q4) begin
            if (t.speed_q4 < SPEED_MID_Q4) begin
               len += 64'(amber_extra);
            end else if (t.speed_q4 < SPEED_HIGH_Q4) begin
               len += (64'(amber_extra) * 64'(SPEED_HIGH_Q4 - t.speed_q4)) / SCALED_EXT_DIV;
            end
         end
         if (t.raining) begin
            len += 64'(rain_extra);
         end
         return len;
      endfunction

      // advance one tick and queue the lamps it should show
      function void note_tick(req_type t);
         rsp_type         lamps;
         bit              leave;
         longint unsigned walk_end;
         longint unsigned blink_end;
         lamps = '0;
         leave = 1'b0;
         if (phase_ms < TICK_TIMER_MAX) begin
            phase_ms++;
         end
         lamps.phase = light_phase;
         case (light_phase)
            PH_AMBER: begin
               lamps.car_amber = 1'b1;
               lamps.walk_red  = 1'b1;
               // first tick with a vehicle decides the report, slow or not
               if (t.vehicle_present && !speed_sent) begin
                  if (t.speed_q4 > SPEED_LOW_Q4) begin
                     lamps.speed_report   = 1'b1;
                     lamps.reported_speed = t.speed_q4;
                  end
                  speed_sent = 1'b1;
               end
               if (phase_ms >= amber_ms(t)) begin
                  light_phase = PH_RED;
                  leave       = 1'b1;
               end
            end
            PH_RED: begin
               walk_end      = 64'(walk_len);
               blink_end     = 64'(walk_len) + 64'(blink_len);
               lamps.car_red = 1'b1;
               if (phase_ms < walk_end) begin
                  lamps.walk_green = 1'b1;
               end else if (phase_ms < blink_end) begin
                  lamps.walk_green = ((phase_ms - walk_end) % BLINK_PERIOD_MS) < BLINK_ON_MS;
               end else begin
                  lamps.walk_red = 1'b1;
                  if (phase_ms >= 64'(red_min)) begin
                     light_phase = PH_GREEN;
                     leave       = 1'b1;
                  end
               end
            end
            default: begin
               lamps.car_green = 1'b1;
               lamps.walk_red  = 1'b1;
               if (phase_ms >= 64'(green_len)) begin
                  light_phase = PH_AMBER;
                  speed_sent  = 1'b0;
                  leave       = 1'b1;
               end
            end
         endcase
         if (leave) begin
            phase_ms = 0;
         end
         expected_lamps.push_back(lamps);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      // check one accepted result against the oldest prediction
      function void check_lamps(rsp_type got);
         rsp_type want;
         if (expected_lamps.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_lamps.pop_front();
         compare_field("car_green", want.car_green, got.car_green);
         compare_field("car_amber", want.car_amber, got.car_amber);
         compare_field("car_red", want.car_red, got.car_red);
         compare_field("walk_green", want.walk_green, got.walk_green);
         compare_field("walk_red", want.walk_red, got.walk_red);
         compare_field("phase", want.phase, got.phase);
         compare_field("speed_report", want.speed_report, got.speed_report);
         compare_field("reported_speed", want.reported_speed, got.reported_speed);
      endfunction

      function int unsigned pending();
         return expected_lamps.size();
      endfunction

   endclass

endpackage

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives 1 ms ticks and timing register writes into the traffic light
// controller and checks every lamp/report transaction against a predictor.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   import atlc_pkg::*;
   import atlc_tb_pkg::*;

   localparam int unsigned DRAIN_CYCLES    = 8;
   localparam int unsigned HOLD_OFF_CYCLES = 300;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;

   lamp_scoreboard sb = new();
   int unsigned    ticks_sent = 0;
   bit             hold_off_req = 1'b0;

   adaptive_traffic_light_controller #(
      .TIMER_WIDTH(TICK_TIMER_W)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop
   initial begin
      #1_000_000;
      $display("tb_top failed");
      $finish;
   end

   // speeds at and around the 5, 20 and 50 cm/s thresholds, plus the extremes
   function automatic logic [SPEED_W-1:0] speed_edge(int unsigned k);
      case (k)
         0: return '0;
         1: return SPEED_LOW_Q4;
         2: return SPEED_LOW_Q4 + 1'b1;
         3: return SPEED_MID_Q4 - 1'b1;
         4: return SPEED_MID_Q4;
         5: return SPEED_HIGH_Q4 - 1'b1;
         6: return SPEED_HIGH_Q4;
         default: return '1;
      endcase
   endfunction

   function automatic req_type directed_tick(int unsigned i);
      req_type t;
      t.speed_q4        = speed_edge(i % 8);
      t.vehicle_present = (i % 5) != 4;
      t.raining         = (i % 6) >= 3;
      return t;
   endfunction

   function automatic req_type random_tick();
      req_type t;
      t.vehicle_present = $urandom_range(0, 9) < 6;
      t.raining         = $urandom_range(0, 9) < 3;
      case ($urandom_range(0, 2))
         0: t.speed_q4 = speed_edge($urandom_range(0, 7));
         1: t.speed_q4 = SPEED_W'($urandom_range(0, SPEED_HIGH_Q4 + 100));
         default: t.speed_q4 = SPEED_W'($urandom);
      endcase
      return t;
   endfunction

   // one register write; leaves csr_valid high for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_timing(index, value);
      @(negedge clock);
   endtask

   // load all timing registers once the block has gone quiet
   task automatic configure(input logic [CFG_W-1:0] g, ab, rm, wk, bl, ex, rn);
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_reg(CSR_GREEN, g);
      write_reg(CSR_AMBER_BASE, ab);
      write_reg(CSR_RED_MIN, rm);
      write_reg(CSR_WALK, wk);
      write_reg(CSR_BLINK, bl);
      write_reg(CSR_AMBER_EXTRA, ex);
      write_reg(CSR_RAIN_EXTRA, rn);
      write_reg(CSR_UNUSED, CFG_W'($urandom));
      csr_valid <= 1'b0;
      // let the walk offset settle
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // one tick transaction; entered and left at a falling edge, valid left high
   task automatic send_tick(input req_type t, input bit drain_first);
      int unsigned gap;
      gap = ticks_sent[6] ? 0 : $urandom_range(0, 4);
      if (gap != 0 || drain_first) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         if (drain_first) begin
            @(negedge clock);
            while (sb.pending() != 0) @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_tick(t);
      ticks_sent++;
      @(negedge clock);
   endtask

   // a run of ticks; longer runs pause halfway until all results are back
   task automatic run_ticks(input int unsigned count, input bit directed);
      req_type t;
      for (int unsigned i = 0; i < count; i++) begin
         t = directed ? directed_tick(i) : random_tick();
         send_tick(t, count >= 100 && i == count / 2);
      end
      req_valid <= 1'b0;
   endtask

   // result side: random stalls, bursts without stalls, one long hold-off
   initial begin : result_sink
      int unsigned gap;
      int unsigned seen;
      seen      = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = seen[6] ? 0 : $urandom_range(0, 4);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            gap          = HOLD_OFF_CYCLES;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_lamps(rsp_data);
         seen++;
         @(negedge clock);
      end
   end

   // stimulus
   initial begin : tick_source
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset timing: long green only
      run_ticks(30, 1'b0);

      // directed: speed thresholds, vehicle and rain combinations, short phases
      configure(16'd2, 16'd1, 16'd4, 16'd1, 16'd2, 16'd6, 16'd3);
      run_ticks(24, 1'b1);

      // all zero: a phase change on every tick
      configure('0, '0, '0, '0, '0, '0, '0);
      run_ticks(100, 1'b0);

      // short phases, red minimum beyond the pedestrian sequence
      configure(16'd3, 16'd2, 16'd6, 16'd2, 16'd3, 16'd10, 16'd4);
      run_ticks(250, 1'b0);

      // maximum extensions; amber ends on a dry tick without a slow vehicle
      configure(16'd1, 16'd2, 16'd2, 16'd0, 16'd0, '1, '1);
      run_ticks(150, 1'b0);

      // long blink window, with a long result stall at the start of the run
      configure(16'd4, 16'd3, 16'd0, 16'd5, 16'd700, 16'd20, 16'd5);
      hold_off_req = 1'b1;
      run_ticks(800, 1'b0);

      // everything at maximum: the current phase holds
      configure('1, '1, '1, '1, '1, '1, '1);
      run_ticks(40, 1'b0);

      // random short timings
      repeat (3) begin
         configure(CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 12)),
                   CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 12)),
                   CFG_W'($urandom_range(0, 12)), CFG_W'($urandom_range(0, 40)),
                   CFG_W'($urandom_range(0, 12)));
         run_ticks(100, 1'b0);
      end

      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

/* adaptive_traffic_light_controller.f */
hw/rtl/atlc_pkg.sv
hw/rtl/atlc_csr.sv
hw/rtl/atlc_amber.sv
hw/rtl/atlc_phase.sv
hw/rtl/adaptive_traffic_light_controller.sv
hw/rtl/atlc_checker.sv
verif/atlc_tb_pkg.sv
verif/tb_top.sv
